/* hdl/smet_pkg.sv */
package smet_pkg;

	localparam int SampleBits = 24;
	localparam int ErrBits    = 24;
	localparam int CntBits    = 32;
	localparam int EvBits     = 16;
	localparam int CfgBits    = 16;
	localparam int DepthBits  = 5;

	localparam logic [15:0]          MergeGapReset    = 16'd32;
	localparam logic [15:0]          MaxEventsReset   = 16'd1000;
	localparam logic [DepthBits-1:0] CompareBitsReset = 5'd16;
	localparam logic [DepthBits-1:0] CompareBitsMin   = 5'd2;
	localparam logic [DepthBits-1:0] CompareBitsMax   = DepthBits'(SampleBits);

	typedef enum logic [1:0] {
		CFG_MERGE_GAP    = 2'd0,
		CFG_MAX_EVENTS   = 2'd1,
		CFG_COMPARE_BITS = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] stimulus_value;
		logic signed [SampleBits-1:0] capture_value;
		logic                         capture_valid;
		logic                         channel_start;
	} sample_t;

	typedef struct packed {
		logic               is_mismatch;
		logic               is_clamp;
		logic [ErrBits-1:0] sample_error;
		logic               event_opened;
		logic [EvBits-1:0]  event_number;
		logic [CntBits-1:0] event_begin;
		logic [CntBits-1:0] event_length;
		logic [ErrBits-1:0] event_peak;
		logic [CntBits-1:0] mismatch_total;
		logic [CntBits-1:0] clamp_total;
		logic [ErrBits-1:0] peak_error;
		logic               events_dropped;
	} result_t;

endpackage

/* hdl/sample_mismatch_event_tracker.sv */
// sample mismatch event tracker
// sample channel: valid/ready, one stimulus/capture pair per item; channel_start
// set on the first pair of a channel clears all running counts and event state
// before that pair is compared.
// result channel: valid/ready, one result item per sample item, carrying this
// pair's verdict and the channel totals after the update.
// configuration: cfg_we, cfg_index, cfg_data; index 0 merge gap, 1 event limit,
// 2 compare depth; other indexes are ignored. write only while idle.
// the input register is loaded on sample acceptance, and the result register is
// loaded from it once the result register is empty or being taken. throughput:
// one item per cycle while the receiver takes results; the comparison and all
// counter updates are combinational between the two registers.
// a stalled receiver holds the result register; one more item waits in the
// input register and the sample channel drops ready until the result is taken.
// reset: all counts and event state zero, merge gap 32, event limit 1000,
// compare depth 16, both channels empty.
module sample_mismatch_event_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_ready,
	input  smet_pkg::sample_t            sample,
	output logic                         result_valid,
	input  logic                         result_ready,
	output smet_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [smet_pkg::CfgBits-1:0] cfg_data
);

	localparam int SB = smet_pkg::SampleBits;
	localparam int EB = smet_pkg::ErrBits;
	localparam int CB = smet_pkg::CntBits;
	localparam int VB = smet_pkg::EvBits;

	logic [15:0]                    merge_gap_q;
	logic [15:0]                    max_events_q;
	logic [smet_pkg::DepthBits-1:0] compare_bits_q;

	logic [CB-1:0] sample_index_q;
	logic [CB-1:0] last_mismatch_index_q;
	logic          seen_mismatch_q;
	logic          storing_event_q;
	logic [VB-1:0] stored_events_q;
	logic [CB-1:0] event_start_q;
	logic [CB-1:0] event_length_q;
	logic [EB-1:0] event_peak_q;
	logic [CB-1:0] mismatch_counter_q;
	logic [CB-1:0] clamp_counter_q;
	logic [EB-1:0] largest_error_q;
	logic          truncated_q;

	logic              valid_s1;
	smet_pkg::sample_t item_s1;
	logic              advance;

	assign advance      = !result_valid || result_ready;
	assign sample_ready = !valid_s1 || advance;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_gap_q    <= smet_pkg::MergeGapReset;
			max_events_q   <= smet_pkg::MaxEventsReset;
			compare_bits_q <= smet_pkg::CompareBitsReset;
		end else if (cfg_we) begin
			unique case (smet_pkg::cfg_index_t'(cfg_index))
				smet_pkg::CFG_MERGE_GAP:    merge_gap_q    <= cfg_data[15:0];
				smet_pkg::CFG_MAX_EVENTS:   max_events_q   <= cfg_data[15:0];
				smet_pkg::CFG_COMPARE_BITS: compare_bits_q <= cfg_data[smet_pkg::DepthBits-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			item_s1 <= sample;
		end
	end

	// per-item comparison and state update
	logic [CB-1:0] b_index, b_last, b_start, b_length, b_mis_cnt, b_clamp_cnt;
	logic [VB-1:0] b_stored;
	logic [EB-1:0] b_peak, b_largest;
	logic          b_seen, b_storing, b_trunc;

	logic [smet_pkg::DepthBits-1:0] depth;
	logic signed [SB-1:0] qs, qr, nfs, nfs_p1;
	logic signed [SB:0]   diff;
	logic [SB:0]          mag;
	logic [EB-1:0]        err;
	logic                 match, clamp, mis, new_event, open_ev, store_ev;

	logic [CB-1:0] n_last, n_start, n_length, n_mis_cnt, n_clamp_cnt;
	logic [VB-1:0] n_stored;
	logic [EB-1:0] n_peak, n_largest;
	logic          n_seen, n_storing, n_trunc;

	always_comb begin
		b_index     = item_s1.channel_start ? '0 : sample_index_q;
		b_last      = item_s1.channel_start ? '0 : last_mismatch_index_q;
		b_seen      = item_s1.channel_start ? 1'b0 : seen_mismatch_q;
		b_storing   = item_s1.channel_start ? 1'b0 : storing_event_q;
		b_stored    = item_s1.channel_start ? '0 : stored_events_q;
		b_start     = item_s1.channel_start ? '0 : event_start_q;
		b_length    = item_s1.channel_start ? '0 : event_length_q;
		b_peak      = item_s1.channel_start ? '0 : event_peak_q;
		b_mis_cnt   = item_s1.channel_start ? '0 : mismatch_counter_q;
		b_clamp_cnt = item_s1.channel_start ? '0 : clamp_counter_q;
		b_largest   = item_s1.channel_start ? '0 : largest_error_q;
		b_trunc     = item_s1.channel_start ? 1'b0 : truncated_q;

		priority if (compare_bits_q < smet_pkg::CompareBitsMin) begin
			depth = smet_pkg::CompareBitsMin;
		end else if (compare_bits_q > smet_pkg::CompareBitsMax) begin
			depth = smet_pkg::CompareBitsMax;
		end else begin
			depth = compare_bits_q;
		end

		qs     = item_s1.stimulus_value;
		qr     = item_s1.capture_valid ? item_s1.capture_value : '0;
		nfs    = {SB{1'b1}} << (depth - 1'b1);
		nfs_p1 = nfs | SB'(1);

		match = item_s1.capture_valid && (qs == qr);
		clamp = item_s1.capture_valid && !match && (qs == nfs) && (qr == nfs_p1);
		mis   = !match && !clamp;

		diff = {qr[SB-1], qr} - {qs[SB-1], qs};
		mag  = diff[SB] ? (SB+1)'(-diff) : diff;
		if (!mis) begin
			err = '0;
		end else if (mag[SB]) begin
			err = '1;
		end else begin
			err = mag[EB-1:0];
		end

		new_event = !b_seen || ((b_index - b_last) > CB'(merge_gap_q));
		open_ev   = mis && new_event && (b_stored < max_events_q);
		store_ev  = (mis && new_event) ? open_ev : b_storing;

		n_storing = store_ev;
		n_stored  = open_ev ? b_stored + 1'b1 : b_stored;
		n_start   = open_ev ? b_index : b_start;
		n_trunc   = b_trunc || (mis && new_event && !open_ev);
		n_length  = b_length;
		n_peak    = open_ev ? '0 : b_peak;
		if (mis && store_ev) begin
			n_length = b_index - n_start + 1'b1;
			if (err > n_peak) begin
				n_peak = err;
			end
		end
		n_seen      = b_seen || mis;
		n_last      = mis ? b_index : b_last;
		n_mis_cnt   = (mis && b_mis_cnt != '1) ? b_mis_cnt + 1'b1 : b_mis_cnt;
		n_clamp_cnt = (clamp && b_clamp_cnt != '1) ? b_clamp_cnt + 1'b1 : b_clamp_cnt;
		n_largest   = (mis && err > b_largest) ? err : b_largest;
	end

	logic fire;
	assign fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q        <= '0;
			last_mismatch_index_q <= '0;
			seen_mismatch_q       <= 1'b0;
			storing_event_q       <= 1'b0;
			stored_events_q       <= '0;
			event_start_q         <= '0;
			event_length_q        <= '0;
			event_peak_q          <= '0;
			mismatch_counter_q    <= '0;
			clamp_counter_q       <= '0;
			largest_error_q       <= '0;
			truncated_q           <= 1'b0;
		end else if (fire) begin
			sample_index_q        <= b_index + 1'b1;
			last_mismatch_index_q <= n_last;
			seen_mismatch_q       <= n_seen;
			storing_event_q       <= n_storing;
			stored_events_q       <= n_stored;
			event_start_q         <= n_start;
			event_length_q        <= n_length;
			event_peak_q          <= n_peak;
			mismatch_counter_q    <= n_mis_cnt;
			clamp_counter_q       <= n_clamp_cnt;
			largest_error_q       <= n_largest;
			truncated_q           <= n_trunc;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result.is_mismatch    <= mis;
			result.is_clamp       <= clamp;
			result.sample_error   <= err;
			result.event_opened   <= open_ev;
			result.event_number   <= n_stored;
			result.event_begin    <= n_start;
			result.event_length   <= n_length;
			result.event_peak     <= n_peak;
			result.mismatch_total <= n_mis_cnt;
			result.clamp_total    <= n_clamp_cnt;
			result.peak_error     <= n_largest;
			result.events_dropped <= n_trunc;
		end
	end

`ifndef SYNTHESIS
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> result_valid)
		else $error("accepted item produced no result");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.channel_start |=>
			(result.mismatch_total == 32'd0 || result.mismatch_total == 32'd1) &&
			(result.clamp_total == 32'd0 || result.clamp_total == 32'd1) &&
			(result.event_number == 16'd0 || result.event_number == 16'd1))
		else $error("channel start did not clear running state");

	a_open_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_opened |->
			result.is_mismatch && result.event_length == 32'd1 &&
			result.event_peak == result.sample_error)
		else $error("new event not started fresh");
`endif

endmodule
